// ----- rtl/bbc_pkg.sv -----
// ----------------------------------------------------------------------------
// bbc_pkg
// Shared types and constants of the bipartite buffer pointer controller.
// ----------------------------------------------------------------------------
package bbc_pkg;

    // Pointer width of the read, write and wrap end pointers
    localparam int POINTER_BITS = 16;
    localparam int PTR_W        = POINTER_BITS;

    // Fixed field widths
    localparam int DATA_W = 16;   // size, capacity, offset
    localparam int CNT_W  = 16;   // used byte count
    localparam int OP_W   = 3;

    // Exact arithmetic width: widest operand plus two carry bits
    localparam int WIDE_W = (PTR_W > DATA_W) ? PTR_W : DATA_W;
    localparam int CALC_W = WIDE_W + 2;

    // Capacity after reset
    localparam logic [DATA_W-1:0] CAP_RESET = DATA_W'(4096);

    // Command codes
    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 3'd0,
        OP_COMMIT  = 3'd1,
        OP_PEEK    = 3'd2,
        OP_RELEASE = 3'd3,
        OP_CLEAR   = 3'd4
    } op_t;

    // Pointer state of the buffer
    typedef struct packed {
        logic [PTR_W-1:0] rd;
        logic [PTR_W-1:0] wr;
        logic [PTR_W-1:0] wrap_end;
        logic [CNT_W-1:0] used;
    } ptr_state_t;

    // One command as taken from the input channel
    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [DATA_W-1:0] size;
    } cmd_t;

    // One result as shown on the output channel
    typedef struct packed {
        logic              ok;
        logic [DATA_W-1:0] offset;
        logic [CNT_W-1:0]  used_bytes;
    } result_t;

endpackage

// ----- rtl/bbc_cmd_eval.sv -----
// ----------------------------------------------------------------------------
// bbc_cmd_eval
// Evaluates one command against the current pointer state: next pointer
// state, success flag, region offset and used byte count.
// ----------------------------------------------------------------------------
module bbc_cmd_eval (
    input  bbc_pkg::ptr_state_t        cur,
    input  bbc_pkg::cmd_t              cmd,
    input  logic [bbc_pkg::DATA_W-1:0] capacity,
    output bbc_pkg::ptr_state_t        nxt,
    output bbc_pkg::result_t           res
);
    import bbc_pkg::*;

    logic [CALC_W-1:0] cap_c;
    logic [CALC_W-1:0] rd_c;
    logic [CALC_W-1:0] wr_c;
    logic [CALC_W-1:0] we_c;
    logic [CALC_W-1:0] sz_c;
    logic [CALC_W-1:0] wr_end;      // write + size, exact
    logic [CALC_W-1:0] rd_end;      // read + size, exact
    logic [CALC_W-1:0] fit_need;    // write + size, plus one when read is zero
    logic              size_zero;
    logic              size_bad;
    logic              wr_ge_rd;
    logic              ok;
    logic [DATA_W-1:0] off;

    // Operands widened so that sums never wrap
    assign cap_c     = CALC_W'(capacity);
    assign rd_c      = CALC_W'(cur.rd);
    assign wr_c      = CALC_W'(cur.wr);
    assign we_c      = CALC_W'(cur.wrap_end);
    assign sz_c      = CALC_W'(cmd.size);
    assign wr_end    = wr_c + sz_c;
    assign rd_end    = rd_c + sz_c;
    assign fit_need  = wr_end + CALC_W'(cur.rd == '0);
    assign size_zero = (cmd.size == '0);
    assign size_bad  = size_zero || (sz_c >= cap_c);
    assign wr_ge_rd  = (wr_c >= rd_c);

    // Command decode and pointer update
    always_comb
    begin
        nxt = cur;
        ok  = 1'b0;
        off = '0;
        case (op_t'(cmd.op))
            OP_RESERVE:
            begin
                if (!size_bad)
                begin
                    if (wr_ge_rd)
                    begin
                        if (fit_need <= cap_c)
                        begin
                            ok  = 1'b1;
                            off = DATA_W'(cur.wr);
                        end
                        else if (sz_c < rd_c)
                        begin
                            ok = 1'b1;
                        end
                        else if ((wr_c == rd_c) && (sz_c == rd_c))
                        begin
                            // empty at the size mark: restart at the base
                            ok     = 1'b1;
                            nxt.rd = '0;
                            nxt.wr = '0;
                        end
                    end
                    else if (wr_end < rd_c)
                    begin
                        ok  = 1'b1;
                        off = DATA_W'(cur.wr);
                    end
                end
            end
            OP_COMMIT:
            begin
                if (size_zero)
                begin
                    ok = 1'b1;
                end
                else if (!size_bad)
                begin
                    if (wr_ge_rd)
                    begin
                        if (fit_need <= cap_c)
                        begin
                            if (wr_end < cap_c)
                            begin
                                ok     = 1'b1;
                                nxt.wr = PTR_W'(wr_end);
                            end
                            else if (wr_end == cap_c)
                            begin
                                ok     = 1'b1;
                                nxt.wr = '0;
                            end
                        end
                        else if (sz_c < rd_c)
                        begin
                            // wrap: mark the end of valid data, restart at base
                            ok           = 1'b1;
                            nxt.wrap_end = cur.wr;
                            nxt.wr       = PTR_W'(cmd.size);
                        end
                    end
                    else if (wr_end < rd_c)
                    begin
                        ok     = 1'b1;
                        nxt.wr = PTR_W'(wr_end);
                    end
                end
                if (ok)
                begin
                    nxt.used = cur.used + CNT_W'(cmd.size);
                end
            end
            OP_PEEK:
            begin
                if (!size_bad)
                begin
                    if (wr_ge_rd)
                    begin
                        if (rd_end <= wr_c)
                        begin
                            ok  = 1'b1;
                            off = DATA_W'(cur.rd);
                        end
                    end
                    else if (rd_c < cap_c)
                    begin
                        if (rd_end <= we_c)
                        begin
                            ok  = 1'b1;
                            off = DATA_W'(cur.rd);
                        end
                        else if ((rd_c == we_c) && (sz_c <= wr_c))
                        begin
                            ok = 1'b1;
                        end
                    end
                end
            end
            OP_RELEASE:
            begin
                if (size_zero)
                begin
                    ok = 1'b1;
                end
                else if (sz_c < cap_c)
                begin
                    if (rd_c < wr_c)
                    begin
                        if (rd_end <= wr_c)
                        begin
                            ok     = 1'b1;
                            nxt.rd = PTR_W'(rd_end);
                        end
                    end
                    else if (rd_c > wr_c)
                    begin
                        if (rd_end < we_c)
                        begin
                            ok     = 1'b1;
                            nxt.rd = PTR_W'(rd_end);
                        end
                        else if (rd_end == we_c)
                        begin
                            // drained exactly to the wrap mark
                            ok           = 1'b1;
                            nxt.wrap_end = PTR_W'(capacity);
                            nxt.rd       = '0;
                        end
                        else if ((rd_c == we_c) && (sz_c <= wr_c))
                        begin
                            ok           = 1'b1;
                            nxt.wrap_end = PTR_W'(capacity);
                            nxt.rd       = PTR_W'(cmd.size);
                        end
                    end
                end
                if (ok)
                begin
                    nxt.used = cur.used - CNT_W'(cmd.size);
                end
            end
            OP_CLEAR:
            begin
                ok           = 1'b1;
                nxt.rd       = '0;
                nxt.wr       = '0;
                nxt.wrap_end = PTR_W'(capacity);
            end
            default:
            begin
                ok = 1'b0;
            end
        endcase
    end

    // Result fields: ok, offset, used byte count
    assign res = {ok, off, nxt.used};

endmodule

// ----- rtl/bipartite_buffer_controller.sv -----
// Each command passes the command register, then its result the result register.
// Throughput: one command per cycle unless the output stalls; the pointer update is a
// single pass of compares and adds from the command register to the result register.
// Output stalls back up through the command register to in_ready.
// Reset: pointers and used count zero, capacity 4096, wrap end at capacity,
// both stages empty.
// ----------------------------------------------------------------------------
// bipartite_buffer_controller
// Pointer controller of a bipartite circular buffer: reserve, commit, peek,
// release and clear commands with one result per command.
// ----------------------------------------------------------------------------
module bipartite_buffer_controller (
    input  logic                       clk,
    input  logic                       rst_n,
    // configuration
    input  logic                       cfg_write_en,
    input  logic [bbc_pkg::DATA_W-1:0] cfg_write_data,
    // command channel
    input  logic                       in_valid,
    output logic                       in_ready,
    input  logic [bbc_pkg::OP_W-1:0]   op,
    input  logic [bbc_pkg::DATA_W-1:0] size,
    // result channel
    output logic                       out_valid,
    input  logic                       out_ready,
    output logic                       ok,
    output logic [bbc_pkg::DATA_W-1:0] offset,
    output logic [bbc_pkg::CNT_W-1:0]  used_bytes
);
    import bbc_pkg::*;

    logic [DATA_W-1:0] capacity_reg;
    ptr_state_t        st_reg;
    ptr_state_t        st_next;
    logic              cmd_vld_reg;
    cmd_t              cmd_reg;
    logic              out_vld_reg;
    result_t           res_reg;
    result_t           res_next;
    logic              advance;
    logic              cmd_fire;
    logic              in_fire;

    // Pipeline flow control
    assign advance  = !out_vld_reg || out_ready;
    assign in_ready = !cmd_vld_reg || advance;
    assign in_fire  = in_valid && in_ready;
    assign cmd_fire = cmd_vld_reg && advance;

    // Command evaluation
    bbc_cmd_eval u_eval (
        .cur      (st_reg),
        .cmd      (cmd_reg),
        .capacity (capacity_reg),
        .nxt      (st_next),
        .res      (res_next)
    );

    // Capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= CAP_RESET;
        end
        else if (cfg_write_en)
        begin
            capacity_reg <= cfg_write_data;
        end
    end

    // Pointer state, updated as each command leaves the command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg.rd       <= '0;
            st_reg.wr       <= '0;
            st_reg.wrap_end <= PTR_W'(CAP_RESET);
            st_reg.used     <= '0;
        end
        else if (cmd_fire)
        begin
            st_reg <= st_next;
        end
    end

    // Stage valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_vld_reg <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                cmd_vld_reg <= in_valid;
            end
            if (advance)
            begin
                out_vld_reg <= cmd_vld_reg;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            cmd_reg.op   <= op;
            cmd_reg.size <= size;
        end
        if (cmd_fire)
        begin
            res_reg <= res_next;
        end
    end

    // Result outputs
    assign out_valid  = out_vld_reg;
    assign ok         = res_reg.ok;
    assign offset     = res_reg.offset;
    assign used_bytes = res_reg.used_bytes;

endmodule

// ----- rtl/bbc_checker.sv -----
// ----------------------------------------------------------------------------
// bbc_checker
// Port-level checks of the bipartite buffer controller, bound to the top.
// ----------------------------------------------------------------------------
module bbc_checker (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       in_valid,
    input  logic                       in_ready,
    input  logic                       out_valid,
    input  logic                       out_ready,
    input  logic                       ok,
    input  logic [bbc_pkg::DATA_W-1:0] offset,
    input  logic [bbc_pkg::CNT_W-1:0]  used_bytes
);
    import bbc_pkg::*;

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(ok) && $stable(offset)
            && $stable(used_bytes))
        else $error("result changed while stalled");

    // A refused command reports a zero offset
    a_fail_offset: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !ok |-> offset == '0)
        else $error("refused command with nonzero offset");

    // Back pressure only comes from a stalled result
    a_ready_cause: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> out_valid && !out_ready)
        else $error("input stalled without output stall");

    // A new result needs an earlier command transfer
    a_no_invent: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_valid && in_ready, 2))
        else $error("result without command transfer");

endmodule

bind bipartite_buffer_controller bbc_checker u_bbc_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .ok         (ok),
    .offset     (offset),
    .used_bytes (used_bytes)
);
